// ===== src/bmw_pkg.sv =====
package bmw_pkg;

  // Raster positions hold a row or column plus the element reach.
  localparam int POS_W       = 13;
  // Column banks let one read fetch every column of the window.
  localparam int BANKS       = 8;
  localparam int BANK_W      = 3;
  // Line rings keep the window rows plus the rows written ahead of the readers.
  localparam int RING        = 32;
  localparam int RING_W      = 5;
  localparam int MASK_STRIDE = 7;
  localparam int MASK_W      = 49;
  localparam int FIFO_DEPTH  = 32;
  localparam int FIFO_AW     = 5;

  localparam logic OP_PUSH = 1'b0;

  typedef enum logic [1:0] {
    MODE_DILATE = 2'd0,
    MODE_ERODE  = 2'd1,
    MODE_OPEN   = 2'd2,
    MODE_CLOSE  = 2'd3
  } bmw_mode_e;

  typedef enum logic [3:0] {
    REG_MODE   = 4'd0,
    REG_WIDTH  = 4'd1,
    REG_HEIGHT = 4'd2,
    REG_SIZE   = 4'd3,
    REG_MASK   = 4'd4,
    REG_CX     = 4'd5,
    REG_CY     = 4'd6,
    REG_FILL   = 4'd7
  } bmw_reg_e;

  // One window evaluation travelling down a pipeline.
  typedef struct packed {
    logic             vld;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } bmw_tag_t;

  // Frame geometry after clamping.
  typedef struct packed {
    logic [POS_W-1:0]  w;
    logic [POS_W-1:0]  h;
    logic [2:0]        side;
    logic [2:0]        cx;
    logic [2:0]        cy;
    logic [MASK_W-1:0] mask;
  } bmw_geom_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] pixel;
    logic       hit;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } bmw_res_t;

endpackage

// ===== src/bmw_store.sv =====
module bmw_store
  import bmw_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  localparam int BD = (MAX_WIDTH + BANKS - 1) / BANKS,
  localparam int BA = (BD > 1) ? $clog2(BD) : 1
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [RING_W-1:0]             wr_row_i,
  input  logic [POS_W-1:0]              wr_col_i,
  input  logic                          wr_bit_i,
  input  logic [BANKS-1:0][BA-1:0]      rd_addr_i,
  output logic [BANKS-1:0][RING-1:0]    rd_data_o
);

  // Each bank holds every eighth column; an entry holds one bit per ring row.
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [RING-1:0] mem_q [BD];
    logic [RING-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_col_i[BANK_W-1:0] == BANK_W'(b))) begin
        mem_q[wr_col_i[BA+BANK_W-1:BANK_W]][wr_row_i] <= wr_bit_i;
      end
      rd_q <= mem_q[rd_addr_i[b]];
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule

// ===== src/bmw_cell.sv =====
module bmw_cell
  import bmw_pkg::*;
#(
  parameter int N   = 7,
  parameter int COL = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bmw_tag_t              tag_i,
  input  logic                  any_i,
  input  logic                  all_i,
  input  logic [N-1:0][N-1:0]   blk_i,
  input  logic [N-1:0][N-1:0]   con_i,
  output bmw_tag_t              tag_o,
  output logic                  any_o,
  output logic                  all_o,
  output logic [N-1:0][N-1:0]   blk_o,
  output logic [N-1:0][N-1:0]   con_o
);

  bmw_tag_t            tag_q;
  logic                any_q, all_q;
  logic [N-1:0][N-1:0] blk_q, con_q;

  // Valid travels with reset; the window bits are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  // Fold this cell's window column into the running any and all terms.
  always_ff @(posedge clk_i) begin
    any_q <= any_i | (|(blk_i[COL] & con_i[COL]));
    all_q <= all_i & ~(|(~blk_i[COL] & con_i[COL]));
    blk_q <= blk_i;
    con_q <= con_i;
  end

  assign tag_o = tag_q;
  assign any_o = any_q;
  assign all_o = all_q;
  assign blk_o = blk_q;
  assign con_o = con_q;

endmodule

// ===== src/bmw_eval.sv =====
module bmw_eval
  import bmw_pkg::*;
#(
  parameter int N = 7,
  parameter int MAX_WIDTH = 1024,
  localparam int BD = (MAX_WIDTH + BANKS - 1) / BANKS,
  localparam int BA = (BD > 1) ? $clog2(BD) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bmw_geom_t                  geom_i,
  input  logic                       erode_i,
  input  bmw_tag_t                   req_i,
  output logic [BANKS-1:0][BA-1:0]   rd_addr_o,
  input  logic [BANKS-1:0][RING-1:0] rd_data_i,
  output bmw_tag_t                   res_o,
  output logic                       hit_o
);

  bmw_tag_t req_q, tag1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q  <= '0;
      tag1_q <= '0;
    end else begin
      req_q  <= req_i;
      tag1_q <= req_q;
    end
  end

  // Bank addresses: the window columns are consecutive, so each bank holds one.
  always_comb begin
    logic signed [POS_W:0] base;
    logic signed [POS_W:0] xa;
    logic [BANK_W-1:0]     off;
    base = $signed({1'b0, req_q.col}) - $signed({{(POS_W-2){1'b0}}, geom_i.cx});
    for (int m = 0; m < BANKS; m++) begin
      off = BANK_W'(m) - base[BANK_W-1:0];
      xa  = base + $signed({{(POS_W-2){1'b0}}, off});
      rd_addr_o[m] = xa[BA+BANK_W-1:BANK_W];
    end
  end

  // Assemble the window from the bank data and mark the cells that count.
  logic [N-1:0][N-1:0] win_blk, win_con;

  always_comb begin
    logic signed [POS_W:0] base;
    logic signed [POS_W:0] rbase;
    logic signed [POS_W:0] xj;
    logic signed [POS_W:0] yi;
    logic                  col_ok;
    logic                  row_ok;
    logic [BANK_W-1:0]     bank;
    base  = $signed({1'b0, tag1_q.col}) - $signed({{(POS_W-2){1'b0}}, geom_i.cx});
    rbase = $signed({1'b0, tag1_q.row}) - $signed({{(POS_W-2){1'b0}}, geom_i.cy});
    for (int j = 0; j < N; j++) begin
      xj     = base + $signed((POS_W+1)'(j));
      col_ok = !xj[POS_W] && (xj[POS_W-1:0] < geom_i.w) && (3'(j) < geom_i.side);
      bank   = xj[BANK_W-1:0];
      for (int i = 0; i < N; i++) begin
        yi     = rbase + $signed((POS_W+1)'(i));
        row_ok = !yi[POS_W] && (yi[POS_W-1:0] < geom_i.h) && (3'(i) < geom_i.side);
        win_blk[j][i] = rd_data_i[bank][yi[RING_W-1:0]];
        win_con[j][i] = col_ok && row_ok && geom_i.mask[i*MASK_STRIDE+j];
      end
    end
  end

  // Chain of column cells, one window column per cell.
  bmw_tag_t            c_tag [N+1];
  logic                c_any [N+1];
  logic                c_all [N+1];
  logic [N-1:0][N-1:0] c_blk [N+1];
  logic [N-1:0][N-1:0] c_con [N+1];

  assign c_tag[0] = tag1_q;
  assign c_any[0] = 1'b0;
  assign c_all[0] = 1'b1;
  assign c_blk[0] = win_blk;
  assign c_con[0] = win_con;

  for (genvar j = 0; j < N; j++) begin : g_cell
    bmw_cell #(.N(N), .COL(j)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tag_i  (c_tag[j]),
      .any_i  (c_any[j]),
      .all_i  (c_all[j]),
      .blk_i  (c_blk[j]),
      .con_i  (c_con[j]),
      .tag_o  (c_tag[j+1]),
      .any_o  (c_any[j+1]),
      .all_o  (c_all[j+1]),
      .blk_o  (c_blk[j+1]),
      .con_o  (c_con[j+1])
    );
  end

  assign res_o = c_tag[N];
  assign hit_o = erode_i ? c_all[N] : c_any[N];

endmodule

// ===== src/bmw_fifo.sv =====
module bmw_fifo
  import bmw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  bmw_res_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output bmw_res_t data_o
);

  bmw_res_t           mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop)    rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop);
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

// ===== src/binary_morphology_window.sv =====
// Results are registered through the column-cell chain into the output queue; in opening and
// closing, output requests first pass a delay line while the intermediate pass is written.
// Throughput: one item per cycle; input stalls only once 32 results are in flight or
// waiting in the output queue.
// Reset: positions clear, registers take their reset values, the line stores are not cleared.
// A configuration write to one of the eight registers clears the positions and starts a new frame.
module binary_morphology_window
  import bmw_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int MAX_ELEMENT = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_idx_i,
  input  logic [MASK_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [7:0]        pixel_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        pixel_out_o,
  output logic              hit_o,
  output logic [9:0]        out_row_o,
  output logic [9:0]        out_col_o,
  output logic              frame_end_o
);

  localparam int BD  = (MAX_WIDTH + BANKS - 1) / BANKS;
  localparam int BA  = (BD > 1) ? $clog2(BD) : 1;
  localparam int DLY = MAX_ELEMENT + 2;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

  function automatic pos_t adv(pos_t p, logic [POS_W-1:0] w);
    pos_t n;
    n = p;
    if (p.col + 1'b1 == w) begin
      n.row = p.row + 1'b1;
      n.col = '0;
    end else begin
      n.col = p.col + 1'b1;
    end
    return n;
  endfunction

  function automatic pos_t need(pos_t p, logic [2:0] a, logic [2:0] b,
                                logic [POS_W-1:0] w, logic [POS_W-1:0] h);
    pos_t n;
    n.row = p.row + POS_W'(a);
    n.col = p.col + POS_W'(b);
    if (n.row > h - 1'b1) n.row = h - 1'b1;
    if (n.col > w - 1'b1) n.col = w - 1'b1;
    return n;
  endfunction

  function automatic logic gt(pos_t p, pos_t q);
    return (p.row > q.row) || ((p.row == q.row) && (p.col > q.col));
  endfunction

  // Configuration registers.
  bmw_mode_e         mode_q;
  logic [10:0]       width_q, height_q;
  logic [2:0]        size_q, cx_q, cy_q;
  logic [MASK_W-1:0] mask_q;
  logic [7:0]        fill_q;
  logic              cfg_clear;

  always_comb begin
    unique case (cfg_idx_i)
      REG_MODE, REG_WIDTH, REG_HEIGHT, REG_SIZE,
      REG_MASK, REG_CX, REG_CY, REG_FILL: cfg_clear = cfg_we_i;
      default:                            cfg_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_DILATE;
      width_q  <= 11'd1024;
      height_q <= 11'd1024;
      size_q   <= 3'd3;
      mask_q   <= '0;
      cx_q     <= 3'd1;
      cy_q     <= 3'd1;
      fill_q   <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:   mode_q   <= bmw_mode_e'(cfg_wdata_i[1:0]);
        REG_WIDTH:  width_q  <= cfg_wdata_i[10:0];
        REG_HEIGHT: height_q <= cfg_wdata_i[10:0];
        REG_SIZE:   size_q   <= cfg_wdata_i[2:0];
        REG_MASK:   mask_q   <= cfg_wdata_i;
        REG_CX:     cx_q     <= cfg_wdata_i[2:0];
        REG_CY:     cy_q     <= cfg_wdata_i[2:0];
        REG_FILL:   fill_q   <= cfg_wdata_i[7:0];
        default:    ;
      endcase
    end
  end

  // Clamped geometry and mode decode.
  bmw_geom_t geom;
  logic [2:0] reach_a, reach_b;
  logic       two_pass, first_erode;

  always_comb begin
    if (width_q == '0)                                  geom.w = POS_W'(1);
    else if ({2'b0, width_q} > POS_W'(MAX_WIDTH))       geom.w = POS_W'(MAX_WIDTH);
    else                                                geom.w = {2'b0, width_q};
    if (height_q == '0)                                 geom.h = POS_W'(1);
    else if ({2'b0, height_q} > POS_W'(MAX_HEIGHT))     geom.h = POS_W'(MAX_HEIGHT);
    else                                                geom.h = {2'b0, height_q};
    if (size_q == '0)                                   geom.side = 3'd1;
    else if (size_q > 3'(MAX_ELEMENT))                  geom.side = 3'(MAX_ELEMENT);
    else                                                geom.side = size_q;
    geom.cx   = (cx_q > geom.side - 1'b1) ? geom.side - 1'b1 : cx_q;
    geom.cy   = (cy_q > geom.side - 1'b1) ? geom.side - 1'b1 : cy_q;
    geom.mask = mask_q;
    reach_a = geom.side - 1'b1 - geom.cy;
    reach_b = geom.side - 1'b1 - geom.cx;
  end

  assign two_pass    = (mode_q == MODE_OPEN) || (mode_q == MODE_CLOSE);
  assign first_erode = (mode_q == MODE_ERODE) || (mode_q == MODE_OPEN);

  // Raster positions of input, intermediate and output pixels.
  pos_t in_q, mid_q, out_q;
  pos_t in_nxt, mid_nxt, feed, mid_need, out_need;
  logic push, mid_go, out_go, out_last, in_fire;
  logic [FIFO_AW:0] reserved_q;

  assign in_ready_o = (reserved_q < (FIFO_AW+1)'(FIFO_DEPTH));
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    push     = (operation_i == OP_PUSH) && (in_q.row < geom.h);
    in_nxt   = push ? adv(in_q, geom.w) : in_q;
    mid_need = need(mid_q, reach_a, reach_b, geom.w, geom.h);
    mid_go   = two_pass && (mid_q.row < geom.h) && gt(in_nxt, mid_need);
    mid_nxt  = mid_go ? adv(mid_q, geom.w) : mid_q;
    feed     = two_pass ? mid_nxt : in_nxt;
    out_need = need(out_q, reach_a, reach_b, geom.w, geom.h);
    out_go   = (out_q.row < geom.h) && gt(feed, out_need);
    out_last = (out_q.row == geom.h - 1'b1) && (out_q.col == geom.w - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q  <= '0;
      mid_q <= '0;
      out_q <= '0;
    end else if (cfg_clear) begin
      in_q  <= '0;
      mid_q <= '0;
      out_q <= '0;
    end else if (in_fire) begin
      if (out_go && out_last) begin
        in_q  <= '0;
        mid_q <= '0;
        out_q <= '0;
      end else begin
        in_q  <= in_nxt;
        mid_q <= mid_nxt;
        out_q <= out_go ? adv(out_q, geom.w) : out_q;
      end
    end
  end

  // Evaluation requests for both passes.
  bmw_tag_t mid_req, out_req, out_eng_req;
  bmw_tag_t dly_q [DLY];

  always_comb begin
    mid_req.vld  = in_fire && !cfg_clear && mid_go;
    mid_req.row  = mid_q.row;
    mid_req.col  = mid_q.col;
    mid_req.last = 1'b0;
    out_req.vld  = in_fire && !cfg_clear && out_go;
    out_req.row  = out_q.row;
    out_req.col  = out_q.col;
    out_req.last = out_last;
  end

  // The second pass waits until the intermediate pixels it needs are written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DLY; i++) dly_q[i] <= '0;
    end else begin
      dly_q[0] <= out_req;
      for (int i = 1; i < DLY; i++) dly_q[i] <= dly_q[i-1];
    end
  end

  assign out_eng_req = two_pass ? dly_q[DLY-1] : out_req;

  // Line stores and the two evaluation chains.
  logic [BANKS-1:0][BA-1:0]   mid_addr, out_addr, st1_addr;
  logic [BANKS-1:0][RING-1:0] st1_data, st2_data, out_data;
  bmw_tag_t mid_res, out_res;
  logic     mid_hit, out_hit;

  assign st1_addr = two_pass ? mid_addr : out_addr;
  assign out_data = two_pass ? st2_data : st1_data;

  bmw_store #(.MAX_WIDTH(MAX_WIDTH)) u_store_src (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire && push),
    .wr_row_i  (in_q.row[RING_W-1:0]),
    .wr_col_i  (in_q.col),
    .wr_bit_i  (pixel_in_i == 8'd0),
    .rd_addr_i (st1_addr),
    .rd_data_o (st1_data)
  );

  bmw_store #(.MAX_WIDTH(MAX_WIDTH)) u_store_mid (
    .clk_i     (clk_i),
    .wr_en_i   (mid_res.vld),
    .wr_row_i  (mid_res.row[RING_W-1:0]),
    .wr_col_i  (mid_res.col),
    .wr_bit_i  (mid_hit && (fill_q == 8'd0)),
    .rd_addr_i (out_addr),
    .rd_data_o (st2_data)
  );

  bmw_eval #(.N(MAX_ELEMENT), .MAX_WIDTH(MAX_WIDTH)) u_eval_mid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .geom_i    (geom),
    .erode_i   (first_erode),
    .req_i     (mid_req),
    .rd_addr_o (mid_addr),
    .rd_data_i (st1_data),
    .res_o     (mid_res),
    .hit_o     (mid_hit)
  );

  bmw_eval #(.N(MAX_ELEMENT), .MAX_WIDTH(MAX_WIDTH)) u_eval_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .geom_i    (geom),
    .erode_i   (two_pass ? !first_erode : first_erode),
    .req_i     (out_eng_req),
    .rd_addr_o (out_addr),
    .rd_data_i (out_data),
    .res_o     (out_res),
    .hit_o     (out_hit)
  );

  // Output queue; every issued result has a slot reserved in advance.
  bmw_res_t push_res, pop_res;

  always_comb begin
    push_res.pixel = out_hit ? fill_q : 8'hFF;
    push_res.hit   = out_hit;
    push_res.row   = out_res.row[9:0];
    push_res.col   = out_res.col[9:0];
    push_res.last  = out_res.last;
  end

  bmw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_res.vld),
    .data_i  (push_res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (pop_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= '0;
    end else begin
      reserved_q <= reserved_q + (FIFO_AW+1)'(out_req.vld)
                    - (FIFO_AW+1)'(out_valid_o && out_ready_i);
    end
  end

  assign pixel_out_o = pop_res.pixel;
  assign hit_o       = pop_res.hit;
  assign out_row_o   = pop_res.row;
  assign out_col_o   = pop_res.col;
  assign frame_end_o = pop_res.last;

  // Checks on the position bookkeeping and the queue reservation.
  a_out_behind_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_q.row < in_q.row) || ((out_q.row == in_q.row) && (out_q.col <= in_q.col)))
    else $error("output position passed the input position");

  a_reserve_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reserved_q <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("output queue over-reserved");

  a_valid_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reserved_q != '0))
    else $error("result beat without a reservation");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_go && out_last) |=> (in_q == '0) && (mid_q == '0) && (out_q == '0))
    else $error("positions did not restart after the last pixel");

endmodule
